>>> rtl/mdsr_pkg.sv
`timescale 1ns / 1ps
// Package for the mouse drag-to-scroll remapper: event codes, payload types
// and the command that travels from the front end to the emitter. No dependencies.
package mdsr_pkg;

  // Event types.
  localparam logic [15:0] EV_SYN = 16'd0;
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;

  // Event codes.
  localparam logic [15:0] REL_X             = 16'd0;
  localparam logic [15:0] REL_Y             = 16'd1;
  localparam logic [15:0] SCROLL_HORIZ      = 16'd6;
  localparam logic [15:0] SCROLL_VERT       = 16'd8;
  localparam logic [15:0] SCROLL_VERT_FINE  = 16'd11;
  localparam logic [15:0] SCROLL_HORIZ_FINE = 16'd12;
  localparam logic [15:0] KEY_LEFT_BUTTON   = 16'd272;
  localparam logic [15:0] KEY_MIDDLE_BUTTON = 16'd274;
  localparam logic [15:0] SYNC_REPORT       = 16'd0;

  // Wheel step values.
  localparam logic signed [31:0] WHEEL_POS    = 32'sd1;
  localparam logic signed [31:0] WHEEL_NEG    = -32'sd1;
  localparam logic signed [31:0] HI_RES_POS   = 32'sd120;
  localparam logic signed [31:0] HI_RES_NEG   = -32'sd120;
  localparam logic signed [31:0] VALUE_ZERO   = 32'sd0;

  // Default depth of the command queue between front end and emitter.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
    logic [63:0]        stamp;
    logic [63:0]        now_stamp;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic [63:0]        out_stamp;
    logic               last;
  } out_item_t;

  // Classified request: remap set when the motion becomes a scroll burst.
  typedef struct packed {
    logic     remap;
    in_item_t item;
  } cmd_t;

  // Status of the command queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

>>> rtl/mdsr_front.sv
`timescale 1ns / 1ps
// Front end of the remapper: accepts requests, tracks the button flags and
// classifies each event as pass-through or scroll burst. Uses mdsr_pkg.
module mdsr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mdsr_pkg::in_item_t in_item,
  input  mdsr_pkg::qstat_t q_stat,
  output logic             q_wr,
  output mdsr_pkg::cmd_t   q_wdata
);
  import mdsr_pkg::*;

  logic left_held;
  logic middle_held;
  logic is_key;
  logic is_motion;

  // A request is taken whenever the queue has room.
  assign q_wr = push && !q_stat.full;

  assign is_key    = (in_item.ev_type == EV_KEY);
  assign is_motion = (in_item.ev_type == EV_REL) &&
                     ((in_item.ev_code == REL_X) || (in_item.ev_code == REL_Y));

  // Motion and key events never coincide, so the current flags decide the remap.
  always_comb begin
    q_wdata.item  = in_item;
    q_wdata.remap = is_motion && left_held && middle_held;
  end

  // Button flags follow the key events for the left and middle buttons.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_held   <= 1'b0;
      middle_held <= 1'b0;
    end else if (q_wr && is_key) begin
      if (in_item.ev_code == KEY_LEFT_BUTTON) begin
        left_held <= (in_item.ev_value != VALUE_ZERO);
      end
      if (in_item.ev_code == KEY_MIDDLE_BUTTON) begin
        middle_held <= (in_item.ev_value != VALUE_ZERO);
      end
    end
  end

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !(q_wr && is_key) |=> ($stable(left_held) && $stable(middle_held)))
    else $error("button flags changed without a key request");

endmodule

>>> rtl/mdsr_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the emitter.
// Uses mdsr_pkg for the command and status types.
module mdsr_queue #(
  parameter int Depth = mdsr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mdsr_pkg::cmd_t   wdata,
  input  logic             rd,
  output mdsr_pkg::cmd_t   head,
  output mdsr_pkg::qstat_t stat
);
  import mdsr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign stat.full     = (count == CntW'(Depth));
  assign stat.nonempty = (count != '0);
  assign head          = slots[rd_ptr];

  // Storage slots take the new command at the write pointer.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("command queue occupancy exceeds its depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> (count != '0))
    else $error("command queue read while empty");

endmodule

>>> rtl/mdsr_back.sv
`timescale 1ns / 1ps
// Emitter of the remapper: walks each command through its results into the output
// register, one per cycle while that register is empty or being popped. Uses mdsr_pkg.
module mdsr_back (
  input  logic              clk,
  input  logic              rst,
  input  mdsr_pkg::cmd_t    cmd,
  input  mdsr_pkg::qstat_t  q_stat,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output mdsr_pkg::out_item_t out_item
);
  import mdsr_pkg::*;

  // Steps of a scroll burst.
  localparam logic [2:0] STEP_LEFT   = 3'd0;
  localparam logic [2:0] STEP_MIDDLE = 3'd1;
  localparam logic [2:0] STEP_WHEEL  = 3'd2;
  localparam logic [2:0] STEP_HI_RES = 3'd3;
  localparam logic [2:0] STEP_SYNC   = 3'd4;

  logic        out_vld;
  logic [2:0]  step;
  logic [2:0]  step_next;
  logic        ld;
  logic        done;
  logic        is_x;
  logic signed [31:0] wheel_val;
  logic signed [31:0] hi_res_val;
  out_item_t   res;

  assign empty = !out_vld;
  assign ld    = q_stat.nonempty && (!out_vld || pop);
  assign done  = !cmd.remap || (step == STEP_SYNC);
  assign cmd_pop = ld && done;
  assign is_x  = (cmd.item.ev_code == REL_X);

  // Sign of the motion, plain and scaled for the hi-res wheel.
  always_comb begin
    if (cmd.item.ev_value == VALUE_ZERO) begin
      wheel_val  = VALUE_ZERO;
      hi_res_val = VALUE_ZERO;
    end else if (cmd.item.ev_value[31]) begin
      wheel_val  = WHEEL_NEG;
      hi_res_val = HI_RES_NEG;
    end else begin
      wheel_val  = WHEEL_POS;
      hi_res_val = HI_RES_POS;
    end
  end

  // Result for the current step, or the event itself when passed through.
  always_comb begin
    res.out_stamp = cmd.item.stamp;
    res.last      = 1'b0;
    res.out_type  = EV_KEY;
    res.out_code  = KEY_LEFT_BUTTON;
    res.out_value = VALUE_ZERO;
    if (!cmd.remap) begin
      res.out_type  = cmd.item.ev_type;
      res.out_code  = cmd.item.ev_code;
      res.out_value = cmd.item.ev_value;
      res.last      = 1'b1;
    end else begin
      unique case (step)
        STEP_LEFT: begin
          res.out_code = KEY_LEFT_BUTTON;
        end
        STEP_MIDDLE: begin
          res.out_code = KEY_MIDDLE_BUTTON;
        end
        STEP_WHEEL: begin
          res.out_type  = EV_REL;
          res.out_code  = is_x ? SCROLL_HORIZ : SCROLL_VERT;
          res.out_value = wheel_val;
        end
        STEP_HI_RES: begin
          res.out_type  = EV_REL;
          res.out_code  = is_x ? SCROLL_HORIZ_FINE : SCROLL_VERT_FINE;
          res.out_value = hi_res_val;
        end
        STEP_SYNC: begin
          res.out_type  = EV_SYN;
          res.out_code  = SYNC_REPORT;
          res.out_stamp = cmd.item.now_stamp;
          res.last      = 1'b1;
        end
        default: begin
          res.out_code = KEY_LEFT_BUTTON;
        end
      endcase
    end
  end

  // Step counter restarts once a command has given its last result.
  always_comb begin
    step_next = step;
    if (ld) begin
      step_next = done ? STEP_LEFT : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_LEFT;
      out_vld <= 1'b0;
    end else begin
      step <= step_next;
      if (ld) begin
        out_vld <= 1'b1;
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Output register holds the oldest waiting result.
  always_ff @(posedge clk) begin
    if (ld) begin
      out_item <= res;
    end
  end

  a_step_in_burst: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_LEFT) |-> (q_stat.nonempty && cmd.remap))
    else $error("burst step advanced without a remap command at the head");

  a_sync_is_last: assert property (@(posedge clk) disable iff (rst)
    (ld && cmd.remap && step == STEP_SYNC) |=> (out_item.last && !empty))
    else $error("sync report of a burst not marked last");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    (ld && cmd.remap && step != STEP_SYNC) |=> !out_item.last)
    else $error("burst result marked last before the sync report");

endmodule

>>> rtl/mouse_drag_to_scroll_remapper.sv
`timescale 1ns / 1ps
// Top level of the mouse drag-to-scroll remapper: front end, command queue and
// emitter. Uses mdsr_pkg, mdsr_front, mdsr_queue and mdsr_back.
//
// The block reads input events (type, code, value, stamps) as queue requests and
// tracks the left and middle button flags. While both are held, a relative X or Y
// motion event turns into five results: left release, middle release, wheel sign,
// hi-res wheel sign times 120 and a sync report stamped with now_stamp; every
// other event comes out unchanged as one result. The emitter writes one result
// per cycle into the output register while that register is empty or being
// popped; a command queue of QueueDepth entries lets new requests be taken
// while a burst is still being emitted. The flag marked last closes the results
// of each request.
module mouse_drag_to_scroll_remapper #(
  parameter int QueueDepth = mdsr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mdsr_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output mdsr_pkg::out_item_t out_item
);
  import mdsr_pkg::*;

  qstat_t q_stat;
  logic   q_wr;
  logic   q_rd;
  cmd_t   q_wdata;
  cmd_t   q_head;

  assign full = q_stat.full;

  // Front end: classify requests and keep the button flags.
  mdsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Queue between classification and emission.
  mdsr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .head  (q_head),
    .stat  (q_stat)
  );

  // Emitter: one result per cycle into the output register while it is empty or popped.
  mdsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_head),
    .q_stat   (q_stat),
    .cmd_pop  (q_rd),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
